### src/roc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roc_pkg: shared types and constants of the relocation overlap classifier
// Field widths, result codes, register indexes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package roc_pkg;

  localparam int ADDR_W = 64;
  localparam int LEN_W  = 8;
  localparam int KIND_W = 2;

  // Stored entry: start address above, length below
  localparam int ENTRY_W = ADDR_W + LEN_W;

  // Result codes for value_kind
  localparam logic [KIND_W-1:0] KIND_NOT_RELOCATED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NORMAL        = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUSPICIOUS    = 2'd2;

  // Operation codes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic CFG_IMAGE_BASE = 1'b0;
  localparam logic CFG_IMAGE_SIZE = 1'b1;

  // Image base plausibility bounds
  localparam logic [ADDR_W-1:0] BASE_LOW_LIMIT  = 64'h0000_0000_0001_0000;
  localparam logic [ADDR_W-1:0] SYS_RANGE_LO    = 64'h0000_7FF0_0000_0000;
  localparam logic [ADDR_W-1:0] SYS_RANGE_HI    = 64'h0000_8000_0000_0000;
  localparam logic [ADDR_W-1:0] KERNEL_BOUNDARY = 64'h8000_0000_0000_0000;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture the input beat, clear the scan
    logic add;        // store the captured entry, or flag it dropped
    logic scan_step;  // read the entry at the scan index, advance
    logic finish;     // load the result register
  } roc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic op_query;
    logic count_zero;
    logic last_issue;
    logic hit;
    logic out_busy;
  } roc_status_t;

endpackage

### src/relocation_overlap_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relocation_overlap_classifier: relocation table with overlap classification
// Stores relocation entries (start, length) and classifies query ranges that
// overlap any entry by whether the disk value falls inside the image.
// ----------------------------------------------------------------------------
//
//  port group | direction | handshake          | payload
//  -----------+-----------+--------------------+------------------------------
//  in_        | input     | in_valid/in_stall  | operation, address, length,
//             |           |                    | disk_value
//  out_       | output    | out_valid/out_stall| value_kind, entry_dropped,
//             |           |                    | base_suspicious
//  cfg_       | input     | cfg_we (no wait)   | cfg_index, cfg_wdata
//
// One item is in flight at a time. An add passes the decide and add states
// to a registered result before the next beat is accepted. A query scans the table through
// the single RAM read port, one entry per cycle, and stops on the first hit;
// with an empty table it goes straight to the result.
// Reset (rst_n low, synchronous) empties the table and clears the image
// registers; no clearing pass is needed, entries above the count are never read.
// A stalled result holds in the output register while the next beat is taken;
// that beat's result waits in the controller until the register is free.
// ----------------------------------------------------------------------------
module relocation_overlap_classifier #(
  parameter int RELOC_ENTRIES = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [roc_pkg::ADDR_W-1:0] cfg_wdata,
  // input beats
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_operation,
  input  logic [roc_pkg::ADDR_W-1:0] in_address,
  input  logic [roc_pkg::LEN_W-1:0]  in_length,
  input  logic [roc_pkg::ADDR_W-1:0] in_disk_value,
  // result beats
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [roc_pkg::KIND_W-1:0] out_value_kind,
  output logic                       out_entry_dropped,
  output logic                       out_base_suspicious
);

  roc_pkg::roc_cmd_t    cmd;
  roc_pkg::roc_status_t status;

  // Sequence each beat: capture, then add or scan, then hand off
  roc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold the table, compare entries, register the result
  roc_dp #(
    .RELOC_ENTRIES (RELOC_ENTRIES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_operation        (in_operation),
    .in_address          (in_address),
    .in_length           (in_length),
    .in_disk_value       (in_disk_value),
    .cmd                 (cmd),
    .status              (status),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_value_kind      (out_value_kind),
    .out_entry_dropped   (out_entry_dropped),
    .out_base_suspicious (out_base_suspicious)
  );

endmodule

### src/roc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roc_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module roc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/roc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roc_ctrl: controller of the relocation overlap classifier
// Sequences one item at a time: capture, add or table scan, result hand-off.
// ----------------------------------------------------------------------------
module roc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  roc_pkg::roc_status_t status,
  output roc_pkg::roc_cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECIDE = 6'b000010,
    ST_ADD    = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_DONE   = 6'b100000
  } roc_state_t;

  roc_state_t state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (!status.op_query) begin
          state_nxt = ST_ADD;
        end else if (status.count_zero) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        // stop early once a hit is known
        priority if (status.hit) begin
          state_nxt = ST_DONE;
        end else if (status.last_issue) begin
          cmd.scan_step = 1'b1;
          state_nxt     = ST_DRAIN;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_decides: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_DECIDE))
    else $error("accepted beat did not move to decide");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !status.out_busy)
    else $error("result loaded over an untaken result");

  a_scan_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> !(cmd.add || cmd.finish || cmd.load))
    else $error("scan step overlaps another command");

endmodule

### src/roc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roc_dp: datapath of the relocation overlap classifier
// Configuration registers, entry table RAM, overlap compare and result register.
// ----------------------------------------------------------------------------
module roc_dp #(
  parameter int RELOC_ENTRIES = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [roc_pkg::ADDR_W-1:0]         cfg_wdata,
  input  logic                               in_operation,
  input  logic [roc_pkg::ADDR_W-1:0]         in_address,
  input  logic [roc_pkg::LEN_W-1:0]          in_length,
  input  logic [roc_pkg::ADDR_W-1:0]         in_disk_value,
  input  roc_pkg::roc_cmd_t                  cmd,
  output roc_pkg::roc_status_t               status,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [roc_pkg::KIND_W-1:0]         out_value_kind,
  output logic                               out_entry_dropped,
  output logic                               out_base_suspicious
);

  localparam int IDX_W = (RELOC_ENTRIES > 1) ? $clog2(RELOC_ENTRIES) : 1;
  localparam int CNT_W = $clog2(RELOC_ENTRIES + 1);
  localparam int AW    = roc_pkg::ADDR_W;

  logic [AW-1:0]               image_base_r, image_size_r;
  logic                        op_r;
  logic [AW-1:0]               addr_r, disk_r;
  logic [roc_pkg::LEN_W-1:0]   len_r;
  logic [AW:0]                 end_r;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic                        cmp_vld_r;
  logic                        hit_r, hit_nxt;
  logic                        dropped_r;
  logic                        in_image_r;
  logic                        full;
  logic                        overlap;
  logic                        base_susp;
  logic [roc_pkg::ENTRY_W-1:0] rd_data;
  logic [AW-1:0]               ent_start;
  logic [roc_pkg::LEN_W-1:0]   ent_len;
  logic [roc_pkg::KIND_W-1:0]  kind;
  logic                        out_valid_r;
  logic [roc_pkg::KIND_W-1:0]  kind_r;
  logic                        out_dropped_r, out_base_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_base_r <= '0;
      image_size_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        roc_pkg::CFG_IMAGE_BASE: image_base_r <= cfg_wdata;
        roc_pkg::CFG_IMAGE_SIZE: image_size_r <= cfg_wdata;
        default:                 image_base_r <= image_base_r;
      endcase
    end
  end

  // captured item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      addr_r <= in_address;
      len_r  <= in_length;
      disk_r <= in_disk_value;
      end_r  <= {1'b0, in_address} + (AW + 1)'(in_length);
    end
  end

  assign full = (count_r == CNT_W'(RELOC_ENTRIES));

  roc_ram #(
    .WIDTH (roc_pkg::ENTRY_W),
    .DEPTH (RELOC_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (cmd.add && !full),
    .waddr (count_r[IDX_W-1:0]),
    .wdata ({addr_r, len_r}),
    .raddr (idx_r),
    .rdata (rd_data)
  );

  assign ent_start = rd_data[roc_pkg::ENTRY_W-1:roc_pkg::LEN_W];
  assign ent_len   = rd_data[roc_pkg::LEN_W-1:0];

  // exact 65-bit compares, nothing wraps
  assign overlap = ({1'b0, ent_start} < end_r) &&
                   (({1'b0, ent_start} + (AW + 1)'(ent_len)) > {1'b0, addr_r});

  always_comb begin
    count_nxt = count_r;
    if (cmd.add && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end
    idx_nxt = idx_r;
    if (cmd.load) begin
      idx_nxt = '0;
    end else if (cmd.scan_step) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
    hit_nxt = hit_r;
    if (cmd.load) begin
      hit_nxt = 1'b0;
    end else if (cmp_vld_r && overlap) begin
      hit_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      idx_r     <= '0;
      hit_r     <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      idx_r     <= idx_nxt;
      hit_r     <= hit_nxt;
      cmp_vld_r <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add) begin
      dropped_r <= full;
    end
    in_image_r <= (image_base_r != '0) && (image_size_r != '0) &&
                  (disk_r >= image_base_r) && ((disk_r - image_base_r) < image_size_r);
  end

  assign base_susp = (image_base_r == '0) ||
                     (image_base_r >= roc_pkg::KERNEL_BOUNDARY) ||
                     ((image_base_r >= roc_pkg::SYS_RANGE_LO) &&
                      (image_base_r < roc_pkg::SYS_RANGE_HI)) ||
                     (image_base_r < roc_pkg::BASE_LOW_LIMIT);

  always_comb begin
    kind = roc_pkg::KIND_NOT_RELOCATED;
    if (op_r == roc_pkg::OP_QUERY && hit_r) begin
      kind = in_image_r ? roc_pkg::KIND_NORMAL : roc_pkg::KIND_SUSPICIOUS;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      kind_r        <= kind;
      out_dropped_r <= (op_r == roc_pkg::OP_ADD) && dropped_r;
      out_base_r    <= base_susp;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_value_kind      = kind_r;
  assign out_entry_dropped   = out_dropped_r;
  assign out_base_suspicious = out_base_r;

  assign status.op_query   = (op_r == roc_pkg::OP_QUERY);
  assign status.count_zero = (count_r == '0);
  assign status.last_issue = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign status.hit        = hit_r;
  assign status.out_busy   = out_valid_r && out_stall;

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.add && full) |=> $stable(count_r))
    else $error("entry count moved on a dropped add");

  a_read_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> (CNT_W'(idx_r) < count_r))
    else $error("scan read beyond stored entries");

  a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("finished result not presented");

endmodule

### verif/tb_relocation_overlap_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_relocation_overlap_classifier: self-checking bench for the classifier
// A short directed script of add and query beats comes first. About 1150
// random beats follow over ten image settings. Every result is checked field
// by field against a local prediction of the relocation table and the image
// registers, while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_relocation_overlap_classifier;

  localparam int TABLE_DEPTH   = 64;
  localparam int RANDOM_BEATS  = 1150;
  localparam int PHASES        = 10;
  localparam int SETTLE_CYCLES = 80;    // full table scan plus margin
  localparam int QUIET_LIMIT   = 4000;  // cycles with no beat moving
  localparam int MAX_REPORTS   = 10;

  localparam logic [roc_pkg::ADDR_W-1:0] ADDR_MAX = '1;

  // Image settings walked by the random part, extremes and range edges among them
  localparam logic [roc_pkg::ADDR_W-1:0] SETTING_BASE [PHASES] = '{
    64'h0000_0001_4000_0000, 64'h0000_7FEF_FFFF_0000, roc_pkg::SYS_RANGE_LO,
    ADDR_MAX,                roc_pkg::BASE_LOW_LIMIT, 64'h0000_0000_0000_FFFF,
    64'h7FFF_FFFF_FFFF_FFFF, roc_pkg::KERNEL_BOUNDARY, roc_pkg::SYS_RANGE_HI,
    64'h0000_0000_0000_0000
  };
  localparam logic [roc_pkg::ADDR_W-1:0] SETTING_SIZE [PHASES] = '{
    64'h0000_0000_0020_0000, 64'h0000_0000_0001_0000, 64'h0000_0000_0000_1000,
    ADDR_MAX,                64'h0000_0000_0000_0000, ADDR_MAX,
    64'h8000_0000_0000_0001, 64'h0000_0000_0000_1000, 64'h0000_0000_0000_0001,
    ADDR_MAX
  };

  // Address neighbourhoods that entries and queries cluster around
  localparam logic [roc_pkg::ADDR_W-1:0] HOT_REGION [4] = '{
    64'h0, 64'h0000_0001_4000_0000, roc_pkg::SYS_RANGE_LO, 64'hFFFF_FFFF_FFFF_F000
  };

  typedef struct packed {
    logic [roc_pkg::KIND_W-1:0] kind;
    logic                       dropped;
    logic                       base_susp;
  } verdict_t;

  localparam verdict_t NOT_TYPED = '0;

  typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_t;

  // One line of the directed script: a beat, or a register write whose
  // value travels in addr
  typedef struct packed {
    row_kind_t                  rkind;
    logic                       reg_sel;
    logic                       op;
    logic [roc_pkg::ADDR_W-1:0] addr;
    logic [roc_pkg::LEN_W-1:0]  len;
    logic [roc_pkg::ADDR_W-1:0] disk;
    logic                       typed;
    verdict_t                   want;
  } row_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_we;
  logic                         cfg_index;
  logic [roc_pkg::ADDR_W-1:0]   cfg_wdata;
  logic                         in_valid;
  logic                         in_stall;
  logic                         in_operation;
  logic [roc_pkg::ADDR_W-1:0]   in_address;
  logic [roc_pkg::LEN_W-1:0]    in_length;
  logic [roc_pkg::ADDR_W-1:0]   in_disk_value;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [roc_pkg::KIND_W-1:0]   out_value_kind;
  logic                         out_entry_dropped;
  logic                         out_base_suspicious;

  // Local copy of the relocation table and the image registers
  logic [roc_pkg::ADDR_W-1:0]   reloc_start [TABLE_DEPTH];
  logic [roc_pkg::LEN_W-1:0]    reloc_len   [TABLE_DEPTH];
  int                           reloc_count = 0;
  logic [roc_pkg::ADDR_W-1:0]   img_base = '0;
  logic [roc_pkg::ADDR_W-1:0]   img_size = '0;

  verdict_t            verdict_q [$];   // results still owed by the block, oldest first
  row_t                script_q [$];    // directed script, walked in order
  int                  mismatches = 0;
  int                  quiet_cycles = 0;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;

  relocation_overlap_classifier #(
    .RELOC_ENTRIES(TABLE_DEPTH)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_address         (in_address),
    .in_length          (in_length),
    .in_disk_value      (in_disk_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_value_kind     (out_value_kind),
    .out_entry_dropped  (out_entry_dropped),
    .out_base_suspicious(out_base_suspicious)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Append one line to the directed script
  function automatic void add_row(input row_t r);
    script_q.insert(script_q.size(), r);
  endfunction

  // --------------------------------------------------------------------------
  // Prediction: apply one accepted beat to the local table and return the
  // result it must produce. Address sums are taken one bit wider so that
  // nothing wraps.
  // --------------------------------------------------------------------------
  function automatic verdict_t classify_beat(input logic op,
                                             input logic [roc_pkg::ADDR_W-1:0] addr,
                                             input logic [roc_pkg::LEN_W-1:0] len,
                                             input logic [roc_pkg::ADDR_W-1:0] disk);
    verdict_t                 v;
    logic [roc_pkg::ADDR_W:0] q_end;
    logic [roc_pkg::ADDR_W:0] e_end;
    logic                     hit;
    v     = '0;
    hit   = 1'b0;
    q_end = {1'b0, addr} + (roc_pkg::ADDR_W + 1)'(len);
    if (op == roc_pkg::OP_ADD) begin
      // Append while there is room, otherwise flag the entry as dropped
      if (reloc_count < TABLE_DEPTH) begin
        reloc_start[reloc_count] = addr;
        reloc_len[reloc_count]   = len;
        reloc_count++;
      end else begin
        v.dropped = 1'b1;
      end
    end else begin
      // Any stored entry with start below the query end and end above the
      // query start counts, zero lengths included
      for (int i = 0; i < reloc_count; i++) begin
        e_end = {1'b0, reloc_start[i]} + (roc_pkg::ADDR_W + 1)'(reloc_len[i]);
        if ({1'b0, reloc_start[i]} < q_end && e_end > {1'b0, addr})
          hit = 1'b1;
      end
      if (hit) begin
        v.kind = roc_pkg::KIND_SUSPICIOUS;
        if (img_base != '0 && img_size != '0 && disk >= img_base &&
            disk - img_base < img_size)
          v.kind = roc_pkg::KIND_NORMAL;
      end
    end
    // Zero falls under the low limit, so it needs no test of its own
    v.base_susp = img_base < roc_pkg::BASE_LOW_LIMIT ||
                  img_base >= roc_pkg::KERNEL_BOUNDARY ||
                  (img_base >= roc_pkg::SYS_RANGE_LO && img_base < roc_pkg::SYS_RANGE_HI);
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Input side: optionally idle, present the beat, hold it until taken, then
  // record what the block owes for it.
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic op, input logic [roc_pkg::ADDR_W-1:0] addr,
                           input logic [roc_pkg::LEN_W-1:0] len,
                           input logic [roc_pkg::ADDR_W-1:0] disk,
                           input logic typed, input verdict_t want);
    verdict_t v;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_address    <= addr;
    in_length     <= len;
    in_disk_value <= disk;
    // Stall is sampled before this edge's updates land, so this sees the
    // value the block used to decide the handshake
    do @(posedge clk); while (in_stall);
    v = classify_beat(op, addr, len, disk);
    verdict_q.insert(verdict_q.size(), typed ? want : v);
  endtask

  // Hold the input channel quiet until every owed result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Write one image register while the block is idle
  task automatic write_reg(input logic sel, input logic [roc_pkg::ADDR_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == roc_pkg::CFG_IMAGE_BASE)
      img_base = value;
    else
      img_size = value;
  endtask

  // --------------------------------------------------------------------------
  // Random beat. Most queries land near the start or end of a stored entry so
  // that hits and near misses both turn up; the rest cluster in the hot
  // regions or go anywhere. Disk values sit mostly on the image edges.
  // --------------------------------------------------------------------------
  task automatic random_beat(input int add_pct);
    logic                       op;
    logic [roc_pkg::ADDR_W-1:0] addr;
    logic [roc_pkg::ADDR_W-1:0] anchor;
    logic [roc_pkg::ADDR_W-1:0] disk;
    logic [roc_pkg::LEN_W-1:0]  len;
    int                         pick;
    int                         idx;
    op   = ($urandom_range(0, 99) < add_pct) ? roc_pkg::OP_ADD : roc_pkg::OP_QUERY;
    pick = $urandom_range(0, 99);
    if (op == roc_pkg::OP_QUERY && reloc_count > 0 && pick < 60) begin
      idx    = $urandom_range(0, reloc_count - 1);
      anchor = reloc_start[idx] + ((pick < 30) ? '0 : {56'd0, reloc_len[idx]});
      addr   = anchor + roc_pkg::ADDR_W'($urandom_range(0, 16)) -
               roc_pkg::ADDR_W'($urandom_range(0, 272));
    end else if (pick < 85) begin
      addr = HOT_REGION[$urandom_range(0, 3)] + roc_pkg::ADDR_W'($urandom_range(0, 'hFFF));
    end else begin
      addr = {$urandom, $urandom};
    end
    case ($urandom_range(0, 7))
      0:       len = '0;
      1:       len = '1;
      default: len = roc_pkg::LEN_W'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: disk = img_base + roc_pkg::ADDR_W'($urandom_range(0, 8)) -
                         roc_pkg::ADDR_W'(4);
      4, 5:       disk = img_base + img_size + roc_pkg::ADDR_W'($urandom_range(0, 8)) -
                         roc_pkg::ADDR_W'(4);
      6:          disk = ($urandom_range(0, 1) != 0) ? ADDR_MAX : '0;
      default:    disk = {$urandom, $urandom};
    endcase
    send_beat(op, addr, len, disk, 1'b0, NOT_TYPED);
  endtask

  // Output side: stall at the rate of the current phase
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Check every taken result against the oldest owed one
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result beat: kind %0d dropped %0b base %0b",
                   out_value_kind, out_entry_dropped, out_base_suspicious);
      end else begin
        want = verdict_q.pop_front();
        if (out_value_kind !== want.kind || out_entry_dropped !== want.dropped ||
            out_base_suspicious !== want.base_susp) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: expected kind %0d dropped %0b base %0b, got %0d %0b %0b",
                     want.kind, want.dropped, want.base_susp,
                     out_value_kind, out_entry_dropped, out_base_suspicious);
        end
      end
    end
  end

  // Watchdog: end the run when nothing has moved for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = roc_pkg::CFG_IMAGE_BASE;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_operation  = roc_pkg::OP_ADD;
    in_address    = '0;
    in_length     = '0;
    in_disk_value = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Registers still at reset: image unknown, so the base is always suspicious
    // and every hit is suspicious. Empty table first.
    add_row('{ROW_BEAT, 1'b0, roc_pkg::OP_QUERY, 64'h0, 8'd0, 64'h0, 1'b1,
              '{roc_pkg::KIND_NOT_RELOCATED, 1'b0, 1'b1}});
    add_row('{ROW_BEAT, 1'b0, roc_pkg::OP_QUERY, ADDR_MAX, 8'd255, ADDR_MAX, 1'b1,
              '{roc_pkg::KIND_NOT_RELOCATED, 1'b0, 1'b1}});
    // Fill a few entries: plain, one running past the top of the address
    // space, one of zero length, one at address zero
    add_row('{ROW_BEAT, 1'b0, roc_pkg::OP_ADD, 64'h1000, 8'd16, 64'h0, 1'b1,
              '{roc_pkg::KIND_NOT_RELOCATED, 1'b0, 1'b1}});
    add_row('{ROW_BEAT, 1'b0, roc_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FFF0, 8'd255, ADDR_MAX,
              1'b1, '{roc_pkg::KIND_NOT_RELOCATED, 1'b0, 1'b1}});
    add_row('{ROW_BEAT, 1'b0, roc_pkg::OP_ADD, 64'h2000, 8'd0, 64'h0, 1'b1,
              '{roc_pkg::KIND_NOT_RELOCATED, 1'b0, 1'b1}});
    add_row('{ROW_BEAT, 1'b0, roc_pkg::OP_ADD, 64'h0, 8'd255, 64'h0, 1'b1,
              '{roc_pkg::KIND_NOT_RELOCATED, 1'b0, 1'b1}});
    // Query ending right at an entry start, one byte inside, right at its end
    add_row('{ROW_BEAT, 1'b0, roc_pkg::OP_QUERY, 64'h0FF8, 8'd8, 64'h0, 1'b0, NOT_TYPED});
    add_row('{ROW_BEAT, 1'b0, roc_pkg::OP_QUERY, 64'h100F, 8'd1, 64'h0, 1'b1,
              '{roc_pkg::KIND_SUSPICIOUS, 1'b0, 1'b1}});
    add_row('{ROW_BEAT, 1'b0, roc_pkg::OP_QUERY, 64'h1010, 8'd4, 64'h0, 1'b0, NOT_TYPED});
    // Top of the address space, where a wrapping sum would go wrong
    add_row('{ROW_BEAT, 1'b0, roc_pkg::OP_QUERY, ADDR_MAX, 8'd255, 64'h0, 1'b1,
              '{roc_pkg::KIND_SUSPICIOUS, 1'b0, 1'b1}});
    add_row('{ROW_BEAT, 1'b0, roc_pkg::OP_QUERY, 64'hFFFF_FFFF_FFFF_FF00, 8'd0, 64'h0,
              1'b0, NOT_TYPED});
    // Zero-length entry and zero-length query
    add_row('{ROW_BEAT, 1'b0, roc_pkg::OP_QUERY, 64'h2000, 8'd1, 64'h0, 1'b0, NOT_TYPED});
    add_row('{ROW_BEAT, 1'b0, roc_pkg::OP_QUERY, 64'h1FFF, 8'd2, 64'h0, 1'b0, NOT_TYPED});
    add_row('{ROW_BEAT, 1'b0, roc_pkg::OP_QUERY, 64'h1008, 8'd0, 64'h0, 1'b0, NOT_TYPED});
    // Known image: disk value on each side of both image edges
    add_row('{ROW_WRITE, roc_pkg::CFG_IMAGE_BASE, roc_pkg::OP_ADD, 64'h1_4000_0000, 8'd0,
              64'h0, 1'b0, NOT_TYPED});
    add_row('{ROW_WRITE, roc_pkg::CFG_IMAGE_SIZE, roc_pkg::OP_ADD, 64'h2000, 8'd0, 64'h0,
              1'b0, NOT_TYPED});
    add_row('{ROW_BEAT, 1'b0, roc_pkg::OP_QUERY, 64'h1000, 8'd1, 64'h1_4000_0000,
              1'b0, NOT_TYPED});
    add_row('{ROW_BEAT, 1'b0, roc_pkg::OP_QUERY, 64'h1000, 8'd1, 64'h1_4000_1FFF,
              1'b0, NOT_TYPED});
    add_row('{ROW_BEAT, 1'b0, roc_pkg::OP_QUERY, 64'h1000, 8'd1, 64'h1_4000_2000,
              1'b0, NOT_TYPED});
    add_row('{ROW_BEAT, 1'b0, roc_pkg::OP_QUERY, 64'h1000, 8'd1, 64'h1_3FFF_FFFF,
              1'b0, NOT_TYPED});
    add_row('{ROW_BEAT, 1'b0, roc_pkg::OP_ADD, 64'h1_4000_0000, 8'd8, 64'h5A5A, 1'b1,
              '{roc_pkg::KIND_NOT_RELOCATED, 1'b0, 1'b0}});
    // Both registers at their maximum: image end lies past the address space
    add_row('{ROW_WRITE, roc_pkg::CFG_IMAGE_BASE, roc_pkg::OP_ADD, ADDR_MAX, 8'd0, 64'h0,
              1'b0, NOT_TYPED});
    add_row('{ROW_WRITE, roc_pkg::CFG_IMAGE_SIZE, roc_pkg::OP_ADD, ADDR_MAX, 8'd0, 64'h0,
              1'b0, NOT_TYPED});
    add_row('{ROW_BEAT, 1'b0, roc_pkg::OP_QUERY, ADDR_MAX, 8'd1, ADDR_MAX, 1'b0,
              NOT_TYPED});
    add_row('{ROW_BEAT, 1'b0, roc_pkg::OP_QUERY, 64'hFF, 8'd255, 64'h0, 1'b0, NOT_TYPED});
    add_row('{ROW_BEAT, 1'b0, roc_pkg::OP_QUERY, 64'hFE, 8'd0, 64'h0, 1'b0, NOT_TYPED});

    foreach (script_q[i]) begin
      if (script_q[i].rkind == ROW_WRITE)
        write_reg(script_q[i].reg_sel, script_q[i].addr);
      else
        send_beat(script_q[i].op, script_q[i].addr, script_q[i].len, script_q[i].disk,
                  script_q[i].typed, script_q[i].want);
    end

    // Random part: one image setting per phase, rotating the idling profile.
    // Adds are frequent early so the table fills and later adds get dropped.
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      write_reg(roc_pkg::CFG_IMAGE_BASE, SETTING_BASE[p]);
      write_reg(roc_pkg::CFG_IMAGE_SIZE, SETTING_SIZE[p]);
      for (int n = 0; n < RANDOM_BEATS / PHASES; n++) begin
        // Hold off once mid-phase until the block has handed back everything
        if (p == 2 && n == 60)
          drain_results();
        random_beat((p < 4) ? 20 : 10);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && verdict_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
